// File: rtl/grid_two_border_reachability_unit_defines.svh
// Assertion macros for the reachability unit.
`ifndef GRID_TWO_BORDER_REACHABILITY_UNIT_DEFINES_SVH
`define GRID_TWO_BORDER_REACHABILITY_UNIT_DEFINES_SVH
// Assert a property on rising clk, ignored during reset.
`define GTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert a property on rising clk including reset cycles.
`define GTB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/gtb_pkg.sv
// Package: types and constants shared by the reachability unit.
`default_nettype none
package gtb_pkg;
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_CUR,
    ST_NREQ,
    ST_NCHK,
    ST_EMIT
  } gtb_state_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [0:0] CFG_ROWS = 1'b0;
  localparam logic [0:0] CFG_COLS = 1'b1;
endpackage
`default_nettype wire

// File: rtl/gtb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module gtb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/grid_two_border_reachability_unit.sv
// Top level: grid load, two flood walks and per-row result emission.
`default_nettype none
`include "grid_two_border_reachability_unit_defines.svh"
// Loads a height grid one transaction per cell in row-major order; the grid
// size comes from cfg registers 0 (rows) and 1 (cols), where 0 reads as 1 and
// values above the maximum saturate. The transaction that carries the last
// cell starts a compute: a sweep clears both mark memories, two depth-first
// flood walks from the first and second borders run over a work stack of
// {row, col} entries, then one out_ transaction per row gives the mask of
// cells reaching both borders. Every memory has a registered read, so a walk
// seeds each border cell with a request and then a check, and expands each
// reached cell by a pop, a read of its own height, then a request and a check
// per neighbor. The row emission addresses, then collects, each mark bit and
// holds each row transaction through any output stall. in_ready is high only
// while loading; a load cell is taken every cycle.
module grid_two_border_reachability_unit
  import gtb_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_height,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_row_index,
  output logic [63:0]      out_both_mask,
  output logic             out_last_row,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW    = AW + 1;

  logic [6:0] rows_cfg_r, cols_cfg_r;
  logic [RW:0] rows;
  logic [CW:0] cols;

  always_comb begin
    if (rows_cfg_r == 7'd0) rows = (RW+1)'(1);
    else if (rows_cfg_r > 7'(MAX_ROWS)) rows = (RW+1)'(MAX_ROWS);
    else rows = (RW+1)'(rows_cfg_r);
    if (cols_cfg_r == 7'd0) cols = (CW+1)'(1);
    else if (cols_cfg_r > 7'(MAX_COLS)) cols = (CW+1)'(MAX_COLS);
    else cols = (CW+1)'(cols_cfg_r);
  end

  gtb_state_t state_r, state_nxt;
  // Current coordinates (loader, clear sweep, seeding, emission).
  logic [RW-1:0] lr_r, lr_nxt;
  logic [CW-1:0] lc_r, lc_nxt;
  logic          walk_r, walk_nxt;   // 0: first border, 1: second
  logic          seed_ph_r, seed_ph_nxt; // seeding: 0 request, 1 check
  // Cell being expanded.
  logic [RW-1:0] cr_r, cr_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [HEIGHT_BITS-1:0] ch_r, ch_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [RW-1:0] nr_r, nr_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic [63:0]   mask_r, mask_nxt;
  logic          emit_ph_r, emit_ph_nxt;

  // Memory ports.
  logic h_we, m1_we, m2_we, s_we;
  logic [AW-1:0] h_wa, h_ra, m_wa, m_ra, s_wa, s_ra;
  logic [HEIGHT_BITS-1:0] h_wd, h_rd;
  logic m1_wd, m2_wd, m1_rd, m2_rd;
  logic [RW+CW-1:0] s_wd, s_rd;

  gtb_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_height (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  gtb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark1 (
    .clk(clk), .we(m1_we), .waddr(m_wa), .wdata(m1_wd), .raddr(m_ra), .rdata(m1_rd));
  gtb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark2 (
    .clk(clk), .we(m2_we), .waddr(m_wa), .wdata(m2_wd), .raddr(m_ra), .rdata(m2_rd));
  gtb_ram #(.WIDTH(RW+CW), .DEPTH(CELLS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c,
                                              input logic [CW:0] nc);
    logic [AW+CW:0] p;
    p = AW'(r) * (CW+1)'(nc) + (AW+CW+1)'(c);
    return p[AW-1:0];
  endfunction

  logic [RW-1:0] last_r;
  logic [CW-1:0] last_c;
  assign last_r = RW'(rows - 1'b1);
  assign last_c = CW'(cols - 1'b1);

  logic in_acc, out_acc, cur_mark;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign cur_mark = walk_r ? m2_rd : m1_rd;

  // Neighbor for the current direction.
  logic          n_ok;
  logic [RW-1:0] n_r;
  logic [CW-1:0] n_c;
  always_comb begin
    n_ok = 1'b0;
    n_r  = cr_r;
    n_c  = cc_r;
    case (dir_r)
      DIR_UP: begin
        n_ok = cr_r != '0;
        n_r  = cr_r - 1'b1;
      end
      DIR_DOWN: begin
        n_ok = cr_r != last_r;
        n_r  = cr_r + 1'b1;
      end
      DIR_LEFT: begin
        n_ok = cc_r != '0;
        n_c  = cc_r - 1'b1;
      end
      DIR_RIGHT: begin
        n_ok = cc_r != last_c;
        n_c  = cc_r + 1'b1;
      end
      default: n_ok = 1'b0;
    endcase
  end

  // Seed coordinates: the first pass walks rows at a fixed column (left or
  // right), the second pass walks columns at a fixed row (top or bottom);
  // seed_b_r selects the pass. A cell already marked is skipped.
  logic seed_b_r, seed_b_nxt;
  logic [RW-1:0] sd_r;
  logic [CW-1:0] sd_c;
  always_comb begin
    if (!seed_b_r) begin
      sd_r = lr_r;
      sd_c = walk_r ? last_c : '0;
    end else begin
      sd_r = walk_r ? last_r : '0;
      sd_c = lc_r;
    end
  end

  logic seed_last;
  assign seed_last = seed_b_r ? (lc_r == last_c) : (lr_r == last_r);

  // Next state and datapath.
  always_comb begin
    state_nxt   = state_r;
    lr_nxt      = lr_r;
    lc_nxt      = lc_r;
    walk_nxt    = walk_r;
    seed_ph_nxt = seed_ph_r;
    seed_b_nxt  = seed_b_r;
    cr_nxt      = cr_r;
    cc_nxt      = cc_r;
    ch_nxt      = ch_r;
    dir_nxt     = dir_r;
    nr_nxt      = nr_r;
    nc_nxt      = nc_r;
    sp_nxt      = sp_r;
    mask_nxt    = mask_r;
    emit_ph_nxt = emit_ph_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (lc_r == last_c) begin
            lc_nxt = '0;
            if (lr_r == last_r) begin
              lr_nxt    = '0;
              state_nxt = ST_CLEAR;
            end else begin
              lr_nxt = lr_r + 1'b1;
            end
          end else begin
            lc_nxt = lc_r + 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        if (lc_r == last_c) begin
          lc_nxt = '0;
          if (lr_r == last_r) begin
            lr_nxt      = '0;
            walk_nxt    = 1'b0;
            seed_ph_nxt = 1'b0;
            seed_b_nxt  = 1'b0;
            sp_nxt      = '0;
            state_nxt   = ST_SEED;
          end else begin
            lr_nxt = lr_r + 1'b1;
          end
        end else begin
          lc_nxt = lc_r + 1'b1;
        end
      end
      ST_SEED: begin
        if (!seed_ph_r) begin
          seed_ph_nxt = 1'b1;
        end else begin
          seed_ph_nxt = 1'b0;
          if (!cur_mark) sp_nxt = sp_r + 1'b1;
          if (seed_last) begin
            if (seed_b_r) begin
              seed_b_nxt = 1'b0;
              lc_nxt     = '0;
              lr_nxt     = '0;
              state_nxt  = ST_POP;
            end else begin
              seed_b_nxt = 1'b1;
              lr_nxt     = '0;
              lc_nxt     = '0;
            end
          end else if (seed_b_r) begin
            lc_nxt = lc_r + 1'b1;
          end else begin
            lr_nxt = lr_r + 1'b1;
          end
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          if (walk_r) begin
            lr_nxt      = '0;
            lc_nxt      = '0;
            emit_ph_nxt = 1'b0;
            mask_nxt    = '0;
            state_nxt   = ST_EMIT;
          end else begin
            walk_nxt  = 1'b1;
            state_nxt = ST_SEED;
          end
        end else begin
          sp_nxt    = sp_r - 1'b1;
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        // Stack read data valid: split the entry, fetch own height.
        cr_nxt    = s_rd[RW+CW-1:CW];
        cc_nxt    = s_rd[CW-1:0];
        dir_nxt   = DIR_UP;
        state_nxt = ST_NREQ;
      end
      ST_NREQ: begin
        if (dir_r == DIR_UP) ch_nxt = h_rd;
        nr_nxt = n_r;
        nc_nxt = n_c;
        if (n_ok) begin
          state_nxt = ST_NCHK;
        end else if (dir_r == DIR_RIGHT) begin
          state_nxt = ST_POP;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      ST_NCHK: begin
        if (!cur_mark && (ch_r <= h_rd)) sp_nxt = sp_r + 1'b1;
        if (dir_r == DIR_RIGHT) begin
          state_nxt = ST_POP;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = ST_NREQ;
        end
      end
      ST_EMIT: begin
        if (!emit_ph_r) begin
          emit_ph_nxt = 1'b1;
        end else begin
          // Collect the addressed bit, then address the next; hold at row end until taken.
          if (out_valid) begin
            if (out_ready) begin
              mask_nxt    = '0;
              lc_nxt      = '0;
              emit_ph_nxt = 1'b0;
              if (lr_r == last_r) begin
                lr_nxt    = '0;
                state_nxt = ST_LOAD;
              end else begin
                lr_nxt = lr_r + 1'b1;
              end
            end
          end else begin
            mask_nxt[lc_r] = m1_rd && m2_rd;
            emit_ph_nxt    = 1'b0;
            lc_nxt         = lc_r + 1'b1;
            if (lc_r == last_c) begin
              lc_nxt      = lc_r;
              emit_ph_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    if (cfg_we && (state_r == ST_LOAD)) begin
      lr_nxt = '0;
      lc_nxt = '0;
    end
  end

  // Row done flag: the row's last bit was collected.
  logic row_done_r, row_done_nxt;
  always_comb begin
    row_done_nxt = row_done_r;
    if (state_r == ST_EMIT) begin
      if (out_acc) row_done_nxt = 1'b0;
      else if (emit_ph_r && !row_done_r && lc_r == last_c) row_done_nxt = 1'b1;
    end else begin
      row_done_nxt = 1'b0;
    end
  end

  // Memory port control and outputs.
  always_comb begin
    in_ready      = state_r == ST_LOAD;
    h_we          = in_acc;
    h_wa          = cell_addr(lr_r, lc_r, cols);
    h_wd          = HEIGHT_BITS'(in_height);
    h_ra          = cell_addr(cr_nxt, cc_nxt, cols);
    m_wa          = cell_addr(lr_r, lc_r, cols);
    m_ra          = cell_addr(lr_nxt, lc_nxt, cols);
    m1_we         = 1'b0;
    m2_we         = 1'b0;
    m1_wd         = 1'b0;
    m2_wd         = 1'b0;
    s_we          = 1'b0;
    s_wa          = sp_r[AW-1:0];
    s_wd          = '0;
    s_ra          = sp_nxt[AW-1:0];
    out_valid     = (state_r == ST_EMIT) && row_done_r;
    out_row_index = 6'(lr_r);
    out_both_mask = mask_r;
    out_last_row  = lr_r == last_r;
    case (state_r)
      ST_CLEAR: begin
        m1_we = 1'b1;
        m2_we = 1'b1;
      end
      ST_SEED: begin
        m_wa = cell_addr(sd_r, sd_c, cols);
        m_ra = cell_addr(sd_r, sd_c, cols);
        if (seed_ph_r && !cur_mark) begin
          m1_we = !walk_r;
          m2_we = walk_r;
          m1_wd = 1'b1;
          m2_wd = 1'b1;
          s_we  = 1'b1;
          s_wd  = {sd_r, sd_c};
        end
      end
      ST_NREQ: begin
        h_ra = cell_addr(n_r, n_c, cols);
        m_ra = cell_addr(n_r, n_c, cols);
      end
      ST_NCHK: begin
        m_wa = cell_addr(nr_r, nc_r, cols);
        h_ra = cell_addr(nr_r, nc_r, cols);
        if (!cur_mark && (ch_r <= h_rd)) begin
          m1_we = !walk_r;
          m2_we = walk_r;
          m1_wd = 1'b1;
          m2_wd = 1'b1;
          s_we  = 1'b1;
          s_wd  = {nr_r, nc_r};
        end
      end
      ST_EMIT: begin
        m_ra = cell_addr(lr_r, lc_r, cols);
        if (out_acc) m_ra = cell_addr(lr_nxt, '0, cols);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      rows_cfg_r <= 7'd64;
      cols_cfg_r <= 7'd64;
      lr_r       <= '0;
      lc_r       <= '0;
      walk_r     <= 1'b0;
      seed_ph_r  <= 1'b0;
      seed_b_r   <= 1'b0;
      sp_r       <= '0;
      emit_ph_r  <= 1'b0;
      row_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lr_r       <= lr_nxt;
      lc_r       <= lc_nxt;
      walk_r     <= walk_nxt;
      seed_ph_r  <= seed_ph_nxt;
      seed_b_r   <= seed_b_nxt;
      sp_r       <= sp_nxt;
      emit_ph_r  <= emit_ph_nxt;
      row_done_r <= row_done_nxt;
      if (cfg_we && cfg_index == CFG_ROWS) rows_cfg_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_COLS) cols_cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cr_r   <= cr_nxt;
    cc_r   <= cc_nxt;
    ch_r   <= ch_nxt;
    dir_r  <= dir_nxt;
    nr_r   <= nr_nxt;
    nc_r   <= nc_nxt;
    mask_r <= mask_nxt;
  end

  `GTB_ASSERT(a_no_in_busy, (state_r != ST_LOAD) |-> !in_ready, "input taken while busy")
  `GTB_ASSERT(a_out_only_emit, out_valid |-> (state_r == ST_EMIT), "result outside emission")
  `GTB_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_both_mask)),
              "result changed while stalled")
  `GTB_ASSERT(a_stack_bound, sp_r <= SW'(CELLS), "stack overflow")
endmodule
`default_nettype wire
